[design/order_statistic_multiset_assert.svh]
// Assertion macros for the checker file of the ordered multiset.
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH

// Checked at every rising edge of clk while arst_n is high.
`define OSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define OSM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/osm_pkg.sv]
// Types and constants shared by the ordered multiset modules.
package osm_pkg;

	localparam int CAPACITY = 64;
	localparam int VALUE_W  = 32;
	localparam int RANK_W   = 7;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_SELECT = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
		logic [RANK_W-1:0]         rank;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] found_value;
		logic [STATUS_W-1:0]       status;
		logic [RANK_W-1:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		logic                      insert_en;
		logic                      remove_en;
		logic signed [VALUE_W-1:0] value;
	} cell_ctrl_t;

endpackage

[design/osm_cell.sv]
// One slot of the sorted list: holds a value and shifts it left or right.
module osm_cell #(
	parameter int IDX  = 0,
	parameter int CMPW = osm_pkg::RANK_W
) (
	input  logic                               clk,
	input  osm_pkg::cell_ctrl_t                ctrl,
	input  logic [CMPW-1:0]                    idx,
	input  logic [CMPW-1:0]                    count,
	input  logic signed [osm_pkg::VALUE_W-1:0] left_value,
	input  logic                               left_take,
	input  logic signed [osm_pkg::VALUE_W-1:0] right_value,
	output logic signed [osm_pkg::VALUE_W-1:0] value,
	output logic                               take,
	output logic [osm_pkg::VALUE_W-1:0]        hit
);

	localparam logic [CMPW-1:0] POS = CMPW'(IDX);

	logic signed [osm_pkg::VALUE_W-1:0] value_q;

	// A slot takes part in an insert when it is the first free slot or holds a larger value.
	assign take  = (POS < count) ? (value_q > ctrl.value) : (POS == count);
	assign value = value_q;
	assign hit   = (idx == POS) ? value_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.insert_en && take) begin
			value_q <= left_take ? left_value : ctrl.value;
		end else if (ctrl.remove_en && (POS >= idx)) begin
			value_q <= right_value;
		end
	end

endmodule

[design/order_statistic_multiset.sv]
// Sorted list of signed values in a row of cells, one operation per cycle unless stalled.
// A row of CAPACITY cells holds the values in ascending order; every cell compares
// against the incoming item at once, and the block accepts one item per clock while
// its results are taken. The result is registered and appears the cycle after the
// item is taken; a new item is accepted whenever the result register is empty or
// its result is being taken in the same cycle.
module order_statistic_multiset #(
	parameter int CAPACITY = osm_pkg::CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  osm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output osm_pkg::rsp_t rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > osm_pkg::RANK_W) ? CW : osm_pkg::RANK_W;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic            rsp_valid_q;
	osm_pkg::rsp_t   rsp_q;
	logic            accept;
	logic [CMPW-1:0] count_x;
	logic [CMPW-1:0] rank_x;
	logic [CMPW-1:0] idx_x;
	logic            rank_ok;
	logic            full;
	logic            ins_ok;
	logic            sel_ok;
	logic            rem_ok;
	osm_pkg::status_t    status_d;
	osm_pkg::cell_ctrl_t ctrl;
	logic [osm_pkg::VALUE_W-1:0] hit_or;

	logic signed [osm_pkg::VALUE_W-1:0] cell_value [CAPACITY];
	logic                               cell_take  [CAPACITY];
	logic [osm_pkg::VALUE_W-1:0]        cell_hit   [CAPACITY];

	assign accept    = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign count_x = CMPW'(count_q);
	assign rank_x  = CMPW'(req.rank);
	assign idx_x   = rank_x - CMPW'(1);
	assign rank_ok = (rank_x != '0) && (rank_x <= count_x);
	assign full    = count_x >= CMPW'(CAPACITY);

	always_comb begin
		ins_ok   = 1'b0;
		sel_ok   = 1'b0;
		rem_ok   = 1'b0;
		status_d = osm_pkg::STATUS_OK;
		unique case (osm_pkg::kind_t'(req.kind))
			osm_pkg::KIND_INSERT: begin
				ins_ok   = !full;
				status_d = full ? osm_pkg::STATUS_FULL : osm_pkg::STATUS_OK;
			end
			osm_pkg::KIND_SELECT: begin
				sel_ok   = rank_ok;
				status_d = rank_ok ? osm_pkg::STATUS_OK : osm_pkg::STATUS_RANGE;
			end
			osm_pkg::KIND_REMOVE: begin
				rem_ok   = rank_ok;
				status_d = rank_ok ? osm_pkg::STATUS_OK : osm_pkg::STATUS_RANGE;
			end
			default: begin
				status_d = osm_pkg::STATUS_RANGE;
			end
		endcase
	end

	assign ctrl.insert_en = accept && ins_ok;
	assign ctrl.remove_en = accept && rem_ok;
	assign ctrl.value     = req.value;

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CW'(1);
		end else if (rem_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [osm_pkg::VALUE_W-1:0] left_value;
		logic                               left_take;
		logic signed [osm_pkg::VALUE_W-1:0] right_value;

		if (g == 0) begin : g_first
			assign left_value = '0;
			assign left_take  = 1'b0;
		end else begin : g_inner
			assign left_value = cell_value[g-1];
			assign left_take  = cell_take[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_value = cell_value[g];
		end else begin : g_body
			assign right_value = cell_value[g+1];
		end

		osm_cell #(
			.IDX  (g),
			.CMPW (CMPW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.idx         (idx_x),
			.count       (count_x),
			.left_value  (left_value),
			.left_take   (left_take),
			.right_value (right_value),
			.value       (cell_value[g]),
			.take        (cell_take[g]),
			.hit         (cell_hit[g])
		);
	end

	always_comb begin
		hit_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_or = hit_or | cell_hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.found_value <= (sel_ok || rem_ok) ? $signed(hit_or) : '0;
			rsp_q.status      <= status_d;
			rsp_q.entry_count <= osm_pkg::RANK_W'(count_d);
		end
	end

endmodule

[design/osm_checker.sv]
// Port-level checks on the ordered multiset, bound to its top level.
`include "order_statistic_multiset_assert.svh"

module osm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input osm_pkg::rsp_t rsp
);

	`OSM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "Stalled item changed or dropped.")
	`OSM_ASSERT(a_rsp_follows, req_valid && req_ready |=> rsp_valid, "Accepted item gave no result in the next cycle.")
	`OSM_ASSERT(a_rsp_cause, $rose(rsp_valid) |-> $past(req_valid && req_ready), "Result appeared without an accepted item.")
	`OSM_ASSERT(a_fail_zero, rsp_valid && (rsp.status == osm_pkg::STATUS_RANGE || rsp.status == osm_pkg::STATUS_FULL) |-> rsp.found_value == '0, "Failed operation returned a value.")
	`OSM_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !rsp_valid, "Result valid during reset.")

endmodule

bind order_statistic_multiset osm_checker u_osm_checker (.*);
